FILE: rtl/core/bcs_pkg.sv
// Shared types and constants for the Bezier curve sampler.
// Used by the controller, the datapath and the top level; no dependencies.
package bcs_pkg;

  localparam int MAX_POINTS_DEF  = 16;
  localparam int MAX_SAMPLES_DEF = 64;
  localparam int COORD_WIDTH_DEF = 32;

  localparam int IO_WIDTH    = 32;
  localparam int LIMIT_WIDTH = 17;
  localparam int COUNT_WIDTH = 7;
  localparam int OP_WIDTH    = 2;

  localparam logic [LIMIT_WIDTH-1:0] ONE_Q16     = 17'd65536;
  localparam logic [COUNT_WIDTH-1:0] MIN_SAMPLES = 7'd2;

  // The parameter divider retires one quotient bit per cycle.
  localparam int DIV_STEPS = LIMIT_WIDTH;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [OP_WIDTH-1:0] {
    OP_CLEAR  = 2'd0,
    OP_ADD    = 2'd1,
    OP_SAMPLE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOAD,
    ST_PASS,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clear;
    logic add;
    logic capture;
    logic div_step;
    logic load;
    logic shift;
    logic ins_lerp;
    logic emit;
    logic last;
    logic p_adv;
  } cmd_t;

endpackage

FILE: rtl/core/bcs_ctrl.sv
// Sequencer of the Bezier curve sampler: decodes ops, runs the divider,
// the de Casteljau passes and the sample loop. Depends on bcs_pkg.
module bcs_ctrl #(
  parameter int MAX_POINTS  = bcs_pkg::MAX_POINTS_DEF,
  parameter int MAX_SAMPLES = bcs_pkg::MAX_SAMPLES_DEF,
  localparam int PCW = $clog2(MAX_POINTS + 1),
  localparam int SCW = $clog2(MAX_SAMPLES + 1),
  localparam int DW  = $clog2(MAX_SAMPLES)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [bcs_pkg::OP_WIDTH-1:0]     op,
  input  logic [bcs_pkg::COUNT_WIDTH-1:0]  sample_count,
  input  logic [PCW-1:0]                   point_count,
  output logic                             busy,
  output logic [PCW-1:0]                   pass_len,
  output logic [DW-1:0]                    div_d,
  output bcs_pkg::cmd_t                    cmd
);

  bcs_pkg::state_t state_r, state_nxt;
  logic [SCW-1:0] cnt_r, cnt_nxt;
  logic [SCW-1:0] idx_r, idx_nxt;
  logic [PCW-1:0] len_r, len_nxt;
  logic [PCW-1:0] k_r, k_nxt;
  logic [bcs_pkg::DIV_CNT_W-1:0] dcnt_r, dcnt_nxt;
  logic [bcs_pkg::COUNT_WIDTH-1:0] cnt_clamp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bcs_pkg::ST_IDLE;
      cnt_r   <= '0;
      idx_r   <= '0;
      len_r   <= '0;
      k_r     <= '0;
      dcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      len_r   <= len_nxt;
      k_r     <= k_nxt;
      dcnt_r  <= dcnt_nxt;
    end
  end

  always_comb begin
    if (sample_count < bcs_pkg::MIN_SAMPLES) begin
      cnt_clamp = bcs_pkg::MIN_SAMPLES;
    end else if (sample_count > bcs_pkg::COUNT_WIDTH'(MAX_SAMPLES)) begin
      cnt_clamp = bcs_pkg::COUNT_WIDTH'(MAX_SAMPLES);
    end else begin
      cnt_clamp = sample_count;
    end
  end

  assign busy     = (state_r != bcs_pkg::ST_IDLE);
  assign pass_len = len_r;
  // The divisor is taken at the accepting edge, so it comes from the item itself.
  assign div_d    = DW'(cnt_clamp - 1'b1);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    len_nxt   = len_r;
    k_nxt     = k_r;
    dcnt_nxt  = dcnt_r;
    cmd       = '0;
    case (state_r)
      bcs_pkg::ST_IDLE: begin
        if (start) begin
          case (bcs_pkg::op_t'(op))
            bcs_pkg::OP_CLEAR: cmd.clear = 1'b1;
            bcs_pkg::OP_ADD:   cmd.add = 1'b1;
            bcs_pkg::OP_SAMPLE: begin
              cmd.capture = 1'b1;
              cnt_nxt     = SCW'(cnt_clamp);
              idx_nxt     = '0;
              dcnt_nxt    = '0;
              state_nxt   = bcs_pkg::ST_DIV;
            end
            default: ;
          endcase
        end
      end
      bcs_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        dcnt_nxt     = dcnt_r + 1'b1;
        if (dcnt_r == bcs_pkg::DIV_CNT_W'(bcs_pkg::DIV_STEPS - 1)) begin
          state_nxt = bcs_pkg::ST_LOAD;
        end
      end
      bcs_pkg::ST_LOAD: begin
        cmd.load = 1'b1;
        len_nxt  = point_count;
        k_nxt    = '0;
        // Zero or one point needs no interpolation pass.
        if (point_count <= PCW'(1)) begin
          state_nxt = bcs_pkg::ST_EMIT;
        end else begin
          state_nxt = bcs_pkg::ST_PASS;
        end
      end
      bcs_pkg::ST_PASS: begin
        cmd.shift    = 1'b1;
        cmd.ins_lerp = (k_r != len_r - 1'b1);
        if (k_r == len_r - 1'b1) begin
          k_nxt   = '0;
          len_nxt = len_r - 1'b1;
          if (len_r == PCW'(2)) begin
            state_nxt = bcs_pkg::ST_EMIT;
          end
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      bcs_pkg::ST_EMIT: begin
        cmd.emit  = 1'b1;
        cmd.p_adv = 1'b1;
        cmd.last  = (idx_r == cnt_r - 1'b1);
        idx_nxt   = idx_r + 1'b1;
        if (idx_r == cnt_r - 1'b1) begin
          state_nxt = bcs_pkg::ST_IDLE;
        end else begin
          state_nxt = bcs_pkg::ST_LOAD;
        end
      end
      default: state_nxt = bcs_pkg::ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/core/bcs_datapath.sv
// Datapath of the Bezier curve sampler: point store, working row with
// three lerp lanes, parameter divider and output registers. Uses bcs_pkg.
module bcs_datapath #(
  parameter int MAX_POINTS  = bcs_pkg::MAX_POINTS_DEF,
  parameter int MAX_SAMPLES = bcs_pkg::MAX_SAMPLES_DEF,
  parameter int COORD_WIDTH = bcs_pkg::COORD_WIDTH_DEF,
  localparam int PCW = $clog2(MAX_POINTS + 1),
  localparam int IW  = $clog2(MAX_POINTS),
  localparam int DW  = $clog2(MAX_SAMPLES)
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  bcs_pkg::cmd_t                          cmd,
  input  logic [PCW-1:0]                         pass_len,
  input  logic [DW-1:0]                          div_d,
  input  logic signed [bcs_pkg::IO_WIDTH-1:0]    point_x,
  input  logic signed [bcs_pkg::IO_WIDTH-1:0]    point_y,
  input  logic signed [bcs_pkg::IO_WIDTH-1:0]    point_z,
  input  logic [bcs_pkg::LIMIT_WIDTH-1:0]        sample_limit,
  output logic [PCW-1:0]                         point_count,
  output logic                                   out_valid,
  output logic signed [bcs_pkg::IO_WIDTH-1:0]    curve_x,
  output logic signed [bcs_pkg::IO_WIDTH-1:0]    curve_y,
  output logic signed [bcs_pkg::IO_WIDTH-1:0]    curve_z,
  output logic                                   last_sample
);

  localparam int CW = COORD_WIDTH;
  localparam int LW = bcs_pkg::LIMIT_WIDTH;

  logic signed [CW-1:0] store_x [MAX_POINTS];
  logic signed [CW-1:0] store_y [MAX_POINTS];
  logic signed [CW-1:0] store_z [MAX_POINTS];
  logic signed [CW-1:0] wx_r [MAX_POINTS];
  logic signed [CW-1:0] wy_r [MAX_POINTS];
  logic signed [CW-1:0] wz_r [MAX_POINTS];
  logic signed [CW-1:0] wx_nxt [MAX_POINTS];
  logic signed [CW-1:0] wy_nxt [MAX_POINTS];
  logic signed [CW-1:0] wz_nxt [MAX_POINTS];

  logic [PCW-1:0] pc_r;
  logic           empty_r;
  logic [DW-1:0]  d_r;
  logic [DW-1:0]  div_rem_r;
  logic [LW-1:0]  div_q_r;
  logic [LW-1:0]  p_r;
  logic [DW-1:0]  acc_rem_r;
  logic           out_valid_r;
  logic           last_r;
  logic signed [bcs_pkg::IO_WIDTH-1:0] cx_r, cy_r, cz_r;

  logic [DW:0]    trial;
  logic [DW:0]    acc_sum;
  logic signed [CW-1:0] ins_x, ins_y, ins_z;
  logic [LW-1:0]  limit_sat;

  function automatic logic signed [CW-1:0] lerp(
    input logic signed [CW-1:0] a,
    input logic signed [CW-1:0] b,
    input logic [LW-1:0]        u
  );
    logic signed [CW:0]      diff;
    logic signed [CW+LW+1:0] dw;
    logic signed [CW+LW+1:0] prod;
    begin
      diff = (CW+1)'(b) - (CW+1)'(a);
      dw   = (CW+LW+2)'(diff);
      prod = dw * $signed({1'b0, u});
      lerp = a + CW'(prod >>> 16);
    end
  endfunction

  assign limit_sat = (sample_limit > bcs_pkg::ONE_Q16) ? bcs_pkg::ONE_Q16 : sample_limit;
  assign trial     = {div_rem_r, div_q_r[LW-1]};
  assign acc_sum   = {1'b0, acc_rem_r} + {1'b0, div_rem_r};

  assign ins_x = cmd.ins_lerp ? lerp(wx_r[0], wx_r[1], p_r) : wx_r[0];
  assign ins_y = cmd.ins_lerp ? lerp(wy_r[0], wy_r[1], p_r) : wy_r[0];
  assign ins_z = cmd.ins_lerp ? lerp(wz_r[0], wz_r[1], p_r) : wz_r[0];

  // Each shift moves the active part of the row left by one; the new value
  // enters at the top of the active part.
  always_comb begin
    for (int j = 0; j < MAX_POINTS; j++) begin
      if (cmd.shift && (PCW'(j + 1) == pass_len)) begin
        wx_nxt[j] = ins_x;
        wy_nxt[j] = ins_y;
        wz_nxt[j] = ins_z;
      end else if (cmd.shift && (PCW'(j + 1) < pass_len)) begin
        wx_nxt[j] = wx_r[(j + 1) % MAX_POINTS];
        wy_nxt[j] = wy_r[(j + 1) % MAX_POINTS];
        wz_nxt[j] = wz_r[(j + 1) % MAX_POINTS];
      end else begin
        wx_nxt[j] = wx_r[j];
        wy_nxt[j] = wy_r[j];
        wz_nxt[j] = wz_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_POINTS; j++) begin
      if (cmd.load) begin
        wx_r[j] <= store_x[j];
        wy_r[j] <= store_y[j];
        wz_r[j] <= store_z[j];
      end else begin
        wx_r[j] <= wx_nxt[j];
        wy_r[j] <= wy_nxt[j];
        wz_r[j] <= wz_nxt[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add && (pc_r != PCW'(MAX_POINTS))) begin
      store_x[pc_r[IW-1:0]] <= CW'(point_x);
      store_y[pc_r[IW-1:0]] <= CW'(point_y);
      store_z[pc_r[IW-1:0]] <= CW'(point_z);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cmd.clear) begin
        pc_r <= '0;
      end else if (cmd.add && (pc_r != PCW'(MAX_POINTS))) begin
        pc_r <= pc_r + 1'b1;
      end
    end
  end

  // Parameter generation: limit / (count-1) once, then an exact running
  // quotient and remainder per sample.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      d_r       <= div_d;
      div_q_r   <= limit_sat;
      div_rem_r <= '0;
      p_r       <= '0;
      acc_rem_r <= '0;
    end else begin
      if (cmd.div_step) begin
        if (trial >= {1'b0, d_r}) begin
          div_rem_r <= DW'(trial - {1'b0, d_r});
          div_q_r   <= {div_q_r[LW-2:0], 1'b1};
        end else begin
          div_rem_r <= DW'(trial);
          div_q_r   <= {div_q_r[LW-2:0], 1'b0};
        end
      end
      if (cmd.p_adv) begin
        if (acc_sum >= {1'b0, d_r}) begin
          acc_rem_r <= DW'(acc_sum - {1'b0, d_r});
          p_r       <= p_r + div_q_r + 1'b1;
        end else begin
          acc_rem_r <= DW'(acc_sum);
          p_r       <= p_r + div_q_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      empty_r <= (pc_r == '0);
    end
    if (cmd.emit) begin
      last_r <= cmd.last;
      if (empty_r) begin
        cx_r <= '0;
        cy_r <= '0;
        cz_r <= '0;
      end else begin
        cx_r <= bcs_pkg::IO_WIDTH'(wx_r[0]);
        cy_r <= bcs_pkg::IO_WIDTH'(wy_r[0]);
        cz_r <= bcs_pkg::IO_WIDTH'(wz_r[0]);
      end
    end
  end

  assign point_count = pc_r;
  assign out_valid   = out_valid_r;
  assign curve_x     = cx_r;
  assign curve_y     = cy_r;
  assign curve_z     = cz_r;
  assign last_sample = last_r;

endmodule

FILE: rtl/core/bezier_curve_sampler_unit.sv
// Top level of the Bezier curve sampler: controller plus datapath.
// Depends on bcs_pkg, bcs_ctrl and bcs_datapath.
//
// Usage: drive in_op and the payload with start high while busy is low;
// the item is taken at that clock edge. Op clear empties the point list,
// op add appends a Q16.16 point (dropped when the list is full), both with
// busy staying low. Op sample raises busy and emits the
// clamped count of curve points on out_curve_x/y/z, each shown for one
// cycle with out_valid high; out_last_sample marks the final one.
// A sample item first runs the parameter divider, then for each sample
// loads the working row from the stored points, runs the passes and
// emits the point: the working row runs one lerp per cycle on each
// axis, and each pass rotates the active part of the row once.
// The receiver cannot stall; every strobe must be taken.
// Reset clears the point count and the sequencer; stored points are
// not cleared.
module bezier_curve_sampler_unit #(
  parameter int MAX_POINTS  = bcs_pkg::MAX_POINTS_DEF,
  parameter int MAX_SAMPLES = bcs_pkg::MAX_SAMPLES_DEF,
  parameter int COORD_WIDTH = bcs_pkg::COORD_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [bcs_pkg::OP_WIDTH-1:0]          in_op,
  input  logic signed [bcs_pkg::IO_WIDTH-1:0]   in_point_x,
  input  logic signed [bcs_pkg::IO_WIDTH-1:0]   in_point_y,
  input  logic signed [bcs_pkg::IO_WIDTH-1:0]   in_point_z,
  input  logic [bcs_pkg::LIMIT_WIDTH-1:0]       in_sample_limit,
  input  logic [bcs_pkg::COUNT_WIDTH-1:0]       in_sample_count,
  output logic                                  out_valid,
  output logic signed [bcs_pkg::IO_WIDTH-1:0]   out_curve_x,
  output logic signed [bcs_pkg::IO_WIDTH-1:0]   out_curve_y,
  output logic signed [bcs_pkg::IO_WIDTH-1:0]   out_curve_z,
  output logic                                  out_last_sample
);

  localparam int PCW = $clog2(MAX_POINTS + 1);
  localparam int DW  = $clog2(MAX_SAMPLES);

  bcs_pkg::cmd_t  cmd;
  logic [PCW-1:0] point_count;
  logic [PCW-1:0] pass_len;
  logic [DW-1:0]  div_d;

  bcs_ctrl #(
    .MAX_POINTS  (MAX_POINTS),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .op           (in_op),
    .sample_count (in_sample_count),
    .point_count  (point_count),
    .busy         (busy),
    .pass_len     (pass_len),
    .div_d        (div_d),
    .cmd          (cmd)
  );

  bcs_datapath #(
    .MAX_POINTS  (MAX_POINTS),
    .MAX_SAMPLES (MAX_SAMPLES),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .pass_len     (pass_len),
    .div_d        (div_d),
    .point_x      (in_point_x),
    .point_y      (in_point_y),
    .point_z      (in_point_z),
    .sample_limit (in_sample_limit),
    .point_count  (point_count),
    .out_valid    (out_valid),
    .curve_x      (out_curve_x),
    .curve_y      (out_curve_y),
    .curve_z      (out_curve_z),
    .last_sample  (out_last_sample)
  );

endmodule
